@@ rtl/ip_range_block_table_defines.svh @@
// Assertion macros shared by the ip_range_block_table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IP_RANGE_BLOCK_TABLE_DEFINES_SVH
`define IP_RANGE_BLOCK_TABLE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while reset is asserted.
`define IPBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipbt same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while reset is asserted.
`define IPBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipbt next-cycle check failed");

`endif

@@ rtl/ipbt_pkg.sv @@
// Shared types, codes and sizing constants for the IPv4 range block table.
// Depends on nothing; imported by the front end, queue, table engine and top level.
package ipbt_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W     = 32;
  localparam int PLEN_W     = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_RANGE  = 2'd1;
  localparam logic [1:0] REQ_CIDR   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(ADDR_W);

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_STORE,
    OP_BAD_PREFIX,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } cmd_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] entry_count;
  } back_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

@@ rtl/ipbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ipbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

@@ rtl/ipbt_front.sv @@
// Front end: takes requests and turns them into table commands with final bounds.
// Depends on ipbt_pkg.
module ipbt_front (
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [ipbt_pkg::ADDR_W-1:0] in_first_address,
  input  logic [ipbt_pkg::ADDR_W-1:0] in_second_address,
  input  logic [ipbt_pkg::PLEN_W-1:0] in_prefix_len,
  output logic                        push,
  output ipbt_pkg::cmd_t              cmd
);
  import ipbt_pkg::*;

  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] base;

  assign push = start && !busy;

  always_comb begin
    mask = '0;
    if (in_prefix_len != '0 && in_prefix_len <= MAX_PREFIX) begin
      mask = {ADDR_W{1'b1}} << (MAX_PREFIX - in_prefix_len);
    end
    base = in_first_address & mask;

    cmd.op = OP_NOP;
    cmd.lo = in_first_address;
    cmd.hi = in_second_address;
    case (in_req_type)
      REQ_LOOKUP: begin
        cmd.op = OP_LOOKUP;
      end
      REQ_RANGE: begin
        cmd.op = OP_STORE;
        if (in_first_address > in_second_address) begin
          cmd.lo = in_second_address;
          cmd.hi = in_first_address;
        end
      end
      REQ_CIDR: begin
        if (in_prefix_len > MAX_PREFIX) begin
          cmd.op = OP_BAD_PREFIX;
        end else begin
          cmd.op = OP_STORE;
          cmd.lo = base;
          cmd.hi = base | ~mask;
        end
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

@@ rtl/ipbt_queue.sv @@
// Short command queue between the front end and the table engine.
// Depends on ipbt_pkg.
module ipbt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipbt_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ipbt_pkg::cmd_t head_cmd
);
  import ipbt_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/ipbt_back.sv @@
// Table engine: stores ranges in the bounds RAM and scans it for lookups.
// Depends on ipbt_pkg and ipbt_ram.
module ipbt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  ipbt_pkg::cmd_t       cmd,
  output logic                 pop,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic                 out_blocked,
  output ipbt_pkg::back_stat_t stat
);
  import ipbt_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              bl_r, bl_nxt;
  logic              we;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  last_idx;
  logic [2*ADDR_W-1:0] rdata_r;
  logic [ADDR_W-1:0] ent_lo, ent_hi;
  logic              hit;

  // Each RAM word holds the low bound in the upper half, the high bound below.
  ipbt_ram #(
    .WIDTH(2 * ADDR_W),
    .DEPTH(MAX_RANGES)
  ) u_bounds (
    .clk    (clk),
    .we     (we),
    .waddr  (cnt_r[IDX_W-1:0]),
    .wdata  ({cmd.lo, cmd.hi}),
    .raddr  (raddr),
    .rdata_r(rdata_r)
  );

  assign ent_lo   = rdata_r[2*ADDR_W-1:ADDR_W];
  assign ent_hi   = rdata_r[ADDR_W-1:0];
  assign hit      = (addr_r >= ent_lo) && (addr_r <= ent_hi);
  assign last_idx = IDX_W'(cnt_r - 1'b1);

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_blocked      = bl_r;
  assign stat.idle        = (state_r == BK_IDLE);
  assign stat.entry_count = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    ov_nxt    = 1'b0;
    st_nxt    = ST_OK;
    bl_nxt    = 1'b0;
    we        = 1'b0;
    pop       = 1'b0;
    raddr     = '0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.op)
            OP_STORE: begin
              ov_nxt = 1'b1;
              if (cnt_r == CNT_W'(MAX_RANGES)) begin
                st_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_BAD_PREFIX: begin
              ov_nxt = 1'b1;
              st_nxt = ST_BAD_PREFIX;
            end
            OP_LOOKUP: begin
              addr_nxt = cmd.lo;
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                // Entry 0 is being read now; its bounds arrive in the scan state.
                idx_nxt   = '0;
                state_nxt = BK_SCAN;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        // The RAM output holds entry idx_r; the read of the next one is launched.
        raddr = idx_r + 1'b1;
        if (hit || idx_r == last_idx) begin
          ov_nxt    = 1'b1;
          bl_nxt    = hit;
          state_nxt = BK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    addr_r <= addr_nxt;
    st_r   <= st_nxt;
    bl_r   <= bl_nxt;
  end

endmodule

@@ rtl/ip_range_block_table.sv @@
// Top level of the IPv4 range block table: front end, command queue, table engine.
// Depends on ipbt_pkg, ipbt_front, ipbt_queue, ipbt_back and the assertion macros.
//
// A request is transferred at a rising edge where start is high and busy is low.
// in_req_type selects a lookup, an explicit range add or a CIDR add; the front end
// orders range bounds and expands a CIDR prefix into its bounds in the same cycle,
// and places the command in a two-entry queue. busy is high while that queue is full.
// The table engine takes one command at a time from the queue. Adds and rejected
// requests finish in the idle state; a lookup reads one stored range per cycle
// from the bounds RAM and stops at the first match or after the last stored entry.
// A command is registered in the queue, taken by the engine, and its result is
// registered there before it is shown.
// Each result is shown for exactly one cycle with out_valid high and is taken at
// the edge ending that cycle; there is no backpressure on the result side.
// Synchronous reset empties the queue, returns the engine to idle and sets the
// entry count to zero; stored bounds are not cleared and are never read unstored.
// An add to a full table reports status full and changes nothing.
`include "ip_range_block_table_defines.svh"

module ip_range_block_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [ipbt_pkg::ADDR_W-1:0] in_first_address,
  input  logic [ipbt_pkg::ADDR_W-1:0] in_second_address,
  input  logic [ipbt_pkg::PLEN_W-1:0] in_prefix_len,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic                        out_blocked
);
  import ipbt_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_not_empty;
  cmd_t       head_cmd;
  logic       pop;
  back_stat_t stat;

  assign busy = q_full;

  ipbt_front u_front (
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_first_address (in_first_address),
    .in_second_address(in_second_address),
    .in_prefix_len    (in_prefix_len),
    .push             (push),
    .cmd              (push_cmd)
  );

  ipbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_cmd (head_cmd)
  );

  ipbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_blocked(out_blocked),
    .stat       (stat)
  );

  `IPBT_ASSERT_NOW(a_count_bounded, 1'b1, stat.entry_count <= CNT_W'(MAX_RANGES))
  `IPBT_ASSERT_NOW(a_full_only_when_full, out_valid && out_status == ST_FULL,
    stat.entry_count == CNT_W'(MAX_RANGES))
  `IPBT_ASSERT_NOW(a_blocked_only_ok, out_valid && out_blocked, out_status == ST_OK)
  `IPBT_ASSERT_NEXT(a_transfer_queued, start && !busy, q_not_empty)
  `IPBT_ASSERT_NOW(a_result_engine_idle, out_valid, stat.idle)

endmodule
